// ----- rtl/avd_pkg.sv -----
// Shared constants and the digit split helper for the ADC voltage display formatter.
`default_nettype none
package avd_pkg;

  localparam int SampleWidth = 10;
  localparam int ScaleWidth  = 17;
  localparam int ProdWidth   = SampleWidth + ScaleWidth;
  localparam int ValueWidth  = 17;

  localparam logic [ScaleWidth-1:0] FULL_SCALE_RESET = 17'd50000;
  localparam logic [9:0]            FULL_CODE        = 10'h3FF;
  localparam logic [ValueWidth-1:0] DECADE_LIMIT     = 17'd100000;

  // floor(2^37 / 1023); the estimate is low by at most one
  localparam int RecipWidth = 28;
  localparam int RecipShift = 37;
  localparam logic [RecipWidth-1:0] RECIP_M = 28'd134348928;

  localparam logic [7:0] CURSOR_HOME = 8'h80;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  // character positions within one run
  localparam logic [3:0] POS_HOME = 4'd0;
  localparam logic [3:0] POS_D4   = 4'd1;
  localparam logic [3:0] POS_DOT  = 4'd2;
  localparam logic [3:0] POS_D3   = 4'd3;
  localparam logic [3:0] POS_D2   = 4'd4;
  localparam logic [3:0] POS_D1   = 4'd5;
  localparam logic [3:0] POS_D0   = 4'd6;
  localparam logic [3:0] POS_V    = 4'd7;
  localparam logic [3:0] POS_LAST = 4'd10;

  typedef struct packed {
    logic [3:0]            digit;
    logic [ValueWidth-1:0] rest;
  } digit_split_t;

  // One decimal digit of rem for place value step; rem is below ten times step.
  function automatic digit_split_t digit_split(input logic [ValueWidth-1:0] rem,
                                               input logic [ValueWidth-1:0] step);
    digit_split_t res;
    logic [20:0]  mult;
    logic [20:0]  best;
    logic [3:0]   dig;
    best = '0;
    dig  = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = 21'(k) * {4'b0, step};
      if ({4'b0, rem} >= mult) begin
        best = mult;
        dig  = 4'(k);
      end
    end
    res.digit = dig;
    res.rest  = ValueWidth'({4'b0, rem} - best);
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/avd_scale.sv -----
// Four-stage scaling pipeline: sample * full_scale / 1023, then modulo 100000.
`default_nettype none
module avd_scale (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             ce,
  input  wire logic                             in_vld,
  input  wire logic [avd_pkg::SampleWidth-1:0]  sample,
  input  wire logic [avd_pkg::ScaleWidth-1:0]   full_scale,
  output logic                                  out_vld,
  output logic [avd_pkg::ValueWidth-1:0]        value
);
  import avd_pkg::*;

  logic                  vld1, vld2, vld3, vld4;
  logic [ProdWidth-1:0]  prod1, prod2;
  logic [ValueWidth-1:0] quot2, quot3, value4;

  logic [ProdWidth+RecipWidth-1:0] recip_prod;
  logic [ProdWidth-1:0]            back_mult;
  logic [ProdWidth-1:0]            remain;
  logic [ValueWidth-1:0]           quot_fix;

  always_comb begin
    recip_prod = {{RecipWidth{1'b0}}, prod1} * {{ProdWidth{1'b0}}, RECIP_M};
    back_mult  = ({{(ProdWidth-ValueWidth){1'b0}}, quot2} << 10)
               - {{(ProdWidth-ValueWidth){1'b0}}, quot2};
    remain     = prod2 - back_mult;
    // estimate may be one low; fix with one compare
    quot_fix   = (remain >= {{(ProdWidth-10){1'b0}}, FULL_CODE}) ? quot2 + 1'b1 : quot2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else if (ce) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prod1  <= {{ScaleWidth{1'b0}}, sample} * {{SampleWidth{1'b0}}, full_scale};
      prod2  <= prod1;
      quot2  <= recip_prod[RecipShift+ValueWidth-1:RecipShift];
      quot3  <= quot_fix;
      // drop the top decimal digit
      value4 <= (quot3 >= DECADE_LIMIT) ? quot3 - DECADE_LIMIT : quot3;
    end
  end

  assign out_vld = vld4;
  assign value   = value4;

endmodule
`default_nettype wire

// ----- rtl/adc_voltage_to_ascii_digits.sv -----
// ADC sample to eleven display/serial characters: scaling, digit split and serializer.
// An accepted sample passes the scaling and digit stages before the serializer takes it.
// The output serializer sends one character per cycle while out_stall is low;
// the eight-stage arithmetic pipeline holds up to eight samples behind it.
// A full stage eight holds the pipeline until loaded; nothing is lost or repeated.
// Reset clears all valid bits and the serializer and loads full_scale with 50000.
`default_nettype none
module adc_voltage_to_ascii_digits (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [avd_pkg::ScaleWidth-1:0]  cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [avd_pkg::SampleWidth-1:0] sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           char_code,
  output logic                                 to_display,
  output logic                                 display_command,
  output logic                                 to_serial,
  output logic                                 last
);
  import avd_pkg::*;

  logic [ScaleWidth-1:0] full_scale;
  logic                  ce;
  logic                  scl_vld;
  logic [ValueWidth-1:0] scl_value;

  logic       vld5, vld6, vld7, vld8;
  logic [3:0] d4_5, d4_6, d4_7, d4_8;
  logic [3:0] d3_6, d3_7, d3_8;
  logic [3:0] d2_7, d2_8;
  logic [3:0] d1_8, d0_8;
  logic [13:0] rem5;
  logic [9:0]  rem6;
  logic [6:0]  rem7;

  logic       busy;
  logic [3:0] cnt;
  logic [3:0] dig4, dig3, dig2, dig1, dig0;
  logic       run_done;
  logic       load;

  digit_split_t sp4, sp3, sp2, sp1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RESET;
    end else if (cfg_wr_en) begin
      full_scale <= cfg_wr_data;
    end
  end

  assign run_done = busy && !out_stall && (cnt == POS_LAST);
  assign load     = vld8 && (!busy || run_done);
  assign ce       = !vld8 || load;
  assign in_stall = !ce;

  avd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_vld     (in_valid),
    .sample     (sample),
    .full_scale (full_scale),
    .out_vld    (scl_vld),
    .value      (scl_value)
  );

  always_comb begin
    sp4 = digit_split(scl_value, 17'd10000);
    sp3 = digit_split({3'b0, rem5}, 17'd1000);
    sp2 = digit_split({7'b0, rem6}, 17'd100);
    sp1 = digit_split({10'b0, rem7}, 17'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
      vld6 <= 1'b0;
      vld7 <= 1'b0;
      vld8 <= 1'b0;
    end else if (ce) begin
      vld5 <= scl_vld;
      vld6 <= vld5;
      vld7 <= vld6;
      vld8 <= vld7;
    end
  end

  // one decimal digit per stage; the last stage splits off both d1 and d0
  always_ff @(posedge clk) begin
    if (ce) begin
      d4_5 <= sp4.digit;
      rem5 <= sp4.rest[13:0];
      d4_6 <= d4_5;
      d3_6 <= sp3.digit;
      rem6 <= sp3.rest[9:0];
      d4_7 <= d4_6;
      d3_7 <= d3_6;
      d2_7 <= sp2.digit;
      rem7 <= sp2.rest[6:0];
      d4_8 <= d4_7;
      d3_8 <= d3_7;
      d2_8 <= d2_7;
      d1_8 <= sp1.digit;
      d0_8 <= sp1.rest[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= POS_HOME;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= POS_HOME;
    end else if (busy && !out_stall) begin
      if (cnt == POS_LAST) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig4 <= d4_8;
      dig3 <= d3_8;
      dig2 <= d2_8;
      dig1 <= d1_8;
      dig0 <= d0_8;
    end
  end

  always_comb begin
    case (cnt)
      POS_HOME: char_code = CURSOR_HOME;
      POS_D4:   char_code = ASCII_ZERO | {4'b0, dig4};
      POS_DOT:  char_code = CHAR_DOT;
      POS_D3:   char_code = ASCII_ZERO | {4'b0, dig3};
      POS_D2:   char_code = ASCII_ZERO | {4'b0, dig2};
      POS_D1:   char_code = ASCII_ZERO | {4'b0, dig1};
      POS_D0:   char_code = ASCII_ZERO | {4'b0, dig0};
      POS_V:    char_code = CHAR_V;
      default:  char_code = CHAR_SPACE;
    endcase
  end

  assign out_valid       = busy;
  assign to_display      = (cnt <= POS_D0);
  assign display_command = (cnt == POS_HOME);
  assign to_serial       = (cnt != POS_HOME);
  assign last            = (cnt == POS_LAST);

endmodule
`default_nettype wire

// ----- rtl/avd_checker.sv -----
// Port-level checks for the voltage display formatter, bound to the top level.
`default_nettype none
module avd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] char_code,
  input wire logic       to_display,
  input wire logic       display_command,
  input wire logic       to_serial,
  input wire logic       last
);
  import avd_pkg::*;

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
    else $error("output item changed under stall");

  // a run never breaks before its last character
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("character run broken");

  // a run that directly follows another opens with cursor home
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid || display_command)
    else $error("run did not start with cursor home");

  a_cmd_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_command |-> char_code == CURSOR_HOME && to_display && !to_serial)
    else $error("malformed display command item");

  // display data is only digits or the decimal point
  a_disp_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && to_display && !display_command |->
      (char_code[7:4] == 4'h3 && char_code[3:0] <= 4'd9) || char_code == CHAR_DOT)
    else $error("bad display data character");

endmodule

bind adc_voltage_to_ascii_digits avd_checker u_avd_checker (.*);
`default_nettype wire
